// ===== sv/assert_macros.svh =====
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define VKVS_ASSERT(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// Same-cycle implication.
`define VKVS_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define VKVS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== sv/vkvs_pkg.sv =====
`default_nettype none
package vkvs_pkg;

  localparam int LOG_DEPTH = 1024;
  localparam int KEY_BITS  = 32;

  localparam int KEY_IN_W  = 32;
  localparam int VAL_W     = 64;
  localparam int VER_IN_W  = 32;
  localparam int VER_W     = 11;
  localparam int STATUS_W  = 2;

  // key compare width: low KEY_BITS bits of the 32-bit key field
  localparam int KEY_W     = (KEY_BITS < KEY_IN_W) ? KEY_BITS : KEY_IN_W;
  localparam int ADDR_W    = $clog2(LOG_DEPTH);
  localparam int CNT_W     = $clog2(LOG_DEPTH + 1);
  localparam int ENTRY_W   = KEY_W + VAL_W;

  localparam logic [CNT_W-1:0] FULL_COUNT = LOG_DEPTH[CNT_W-1:0];

  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t ST_STORED  = 2'd0;
  localparam status_t ST_FULL    = 2'd1;
  localparam status_t ST_FOUND   = 2'd2;
  localparam status_t ST_MISSING = 2'd3;

  typedef struct packed {
    logic                      command;
    logic [KEY_IN_W-1:0]       key;
    logic signed [VAL_W-1:0]   data_in;
    logic [VER_IN_W-1:0]       as_of_version;
  } req_t;

  typedef struct packed {
    status_t                   status;
    logic signed [VAL_W-1:0]   data_out;
    logic [VER_W-1:0]          new_version;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic    load_req;
    logic    write_en;
    logic    start_scan;
    logic    step_scan;
    logic    out_en;
    status_t out_status;
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic is_query;
    logic full;
    logic v_zero;
    logic hit;
    logic at_bottom;
  } sts_t;

endpackage
`default_nettype wire

// ===== sv/versioned_key_value_store.sv =====
// Channel   Ports                      Handshake
// request   start, busy, request       taken when start && !busy
// result    done, result               valid for the one cycle done is high
//
// An update goes from start through the EXEC state to done. A query with
// nothing to scan does too; otherwise it adds SCAN, reading k log entries
// (up to LOG_DEPTH), one per cycle through the log RAM port.
// A new request is taken in the cycle its predecessor's result is shown.
// Synchronous reset clears the version count and the controller; the log
// RAM is not cleared. The receiver cannot stall: results are not held.
`default_nettype none
`include "assert_macros.svh"
module versioned_key_value_store (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  output logic                busy,
  input  wire vkvs_pkg::req_t request,
  output logic                done,
  output vkvs_pkg::rsp_t      result
);

  vkvs_pkg::ctl_t ctl;
  vkvs_pkg::sts_t sts;
  logic           update_done;

  vkvs_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .ctl   (ctl),
    .busy  (busy)
  );

  vkvs_datapath u_dp (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .ctl     (ctl),
    .sts     (sts),
    .done    (done),
    .result  (result)
  );

  assign update_done = done && (result.status == vkvs_pkg::ST_STORED ||
                                result.status == vkvs_pkg::ST_FULL);

  `VKVS_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy && !done)
  `VKVS_ASSERT_IMPL(a_done_idle, clk, rst, done, !busy)
  `VKVS_ASSERT_IMPL(a_no_write_full, clk, rst, ctl.write_en, !sts.full && !sts.is_query)
  `VKVS_ASSERT_IMPL(a_update_value, clk, rst, update_done, result.data_out == '1)

endmodule
`default_nettype wire

// ===== sv/vkvs_ram.sv =====
`default_nettype none
module vkvs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== sv/vkvs_datapath.sv =====
`default_nettype none
module vkvs_datapath (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire vkvs_pkg::req_t request,
  input  wire vkvs_pkg::ctl_t ctl,
  output vkvs_pkg::sts_t      sts,
  output logic                done,
  output vkvs_pkg::rsp_t      result
);

  vkvs_pkg::req_t                  req;
  logic [vkvs_pkg::CNT_W-1:0]      versions_used;
  logic [vkvs_pkg::ADDR_W-1:0]     idx;
  logic [vkvs_pkg::CNT_W-1:0]      vclamp;
  logic [vkvs_pkg::CNT_W-1:0]      vminus;
  logic [vkvs_pkg::ADDR_W-1:0]     start_addr;
  logic [vkvs_pkg::ADDR_W-1:0]     raddr;
  logic [vkvs_pkg::ENTRY_W-1:0]    wdata;
  logic [vkvs_pkg::ENTRY_W-1:0]    rdata;
  logic [vkvs_pkg::KEY_W-1:0]      rkey;
  logic [vkvs_pkg::VAL_W-1:0]      rval;
  logic [vkvs_pkg::CNT_W-1:0]      used_plus;
  logic [vkvs_pkg::CNT_W+vkvs_pkg::VER_W-1:0] used_wide;
  logic [vkvs_pkg::VER_W-1:0]      nv;

  always_ff @(posedge clk) begin
    if (ctl.load_req) begin
      req <= request;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      versions_used <= '0;
    end else if (ctl.write_en) begin
      versions_used <= used_plus;
    end
  end

  // asked version clamped to the newest one
  always_comb begin
    if (req.as_of_version >
        {{(vkvs_pkg::VER_IN_W - vkvs_pkg::CNT_W){1'b0}}, versions_used}) begin
      vclamp = versions_used;
    end else begin
      vclamp = req.as_of_version[vkvs_pkg::CNT_W-1:0];
    end
  end

  assign vminus     = vclamp - 1'b1;
  assign start_addr = vminus[vkvs_pkg::ADDR_W-1:0];
  assign raddr      = ctl.start_scan ? start_addr : idx - 1'b1;

  // idx tracks the address whose data is on rdata
  always_ff @(posedge clk) begin
    if (ctl.start_scan) begin
      idx <= start_addr;
    end else if (ctl.step_scan) begin
      idx <= idx - 1'b1;
    end
  end

  assign wdata = {req.key[vkvs_pkg::KEY_W-1:0], req.data_in};

  vkvs_ram #(
    .WIDTH (vkvs_pkg::ENTRY_W),
    .DEPTH (vkvs_pkg::LOG_DEPTH)
  ) u_log (
    .clk   (clk),
    .we    (ctl.write_en),
    .waddr (versions_used[vkvs_pkg::ADDR_W-1:0]),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rkey = rdata[vkvs_pkg::ENTRY_W-1:vkvs_pkg::VAL_W];
  assign rval = rdata[vkvs_pkg::VAL_W-1:0];

  assign used_plus = versions_used + 1'b1;
  assign used_wide = {{vkvs_pkg::VER_W{1'b0}}, used_plus};
  assign nv        = used_wide[vkvs_pkg::VER_W-1:0];

  assign sts.is_query  = (req.command == vkvs_pkg::CMD_QUERY);
  assign sts.full      = (versions_used == vkvs_pkg::FULL_COUNT);
  assign sts.v_zero    = (vclamp == '0);
  assign sts.hit       = (rkey == req.key[vkvs_pkg::KEY_W-1:0]);
  assign sts.at_bottom = (idx == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.out_en;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_en) begin
      result.status      <= ctl.out_status;
      result.data_out    <= (ctl.out_status == vkvs_pkg::ST_FOUND) ? rval : '1;
      result.new_version <= (ctl.out_status == vkvs_pkg::ST_STORED) ? nv : '0;
    end
  end

endmodule
`default_nettype wire

// ===== sv/vkvs_ctrl.sv =====
`default_nettype none
module vkvs_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire vkvs_pkg::sts_t sts,
  output vkvs_pkg::ctl_t      ctl,
  output logic                busy
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    ctl        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          ctl.load_req = 1'b1;
          state_next   = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!sts.is_query) begin
          ctl.out_en = 1'b1;
          if (sts.full) begin
            ctl.out_status = vkvs_pkg::ST_FULL;
          end else begin
            ctl.write_en   = 1'b1;
            ctl.out_status = vkvs_pkg::ST_STORED;
          end
          state_next = S_IDLE;
        end else if (sts.v_zero) begin
          ctl.out_en     = 1'b1;
          ctl.out_status = vkvs_pkg::ST_MISSING;
          state_next     = S_IDLE;
        end else begin
          ctl.start_scan = 1'b1;
          state_next     = S_SCAN;
        end
      end
      S_SCAN: begin
        // one entry checked per cycle, next read already in flight
        if (sts.hit) begin
          ctl.out_en     = 1'b1;
          ctl.out_status = vkvs_pkg::ST_FOUND;
          state_next     = S_IDLE;
        end else if (sts.at_bottom) begin
          ctl.out_en     = 1'b1;
          ctl.out_status = vkvs_pkg::ST_MISSING;
          state_next     = S_IDLE;
        end else begin
          ctl.step_scan = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire
